// ----- src/udphb_pkg.sv -----
// Shared types and constants for the Ethernet/IPv4/UDP header builder.
// Used by every module under src; no dependencies.
package udphb_pkg;

  // Header layout
  localparam int unsigned HDR_WORDS   = 21;
  localparam int unsigned WORD_IDX_W  = 5;
  localparam int unsigned CFG_DATA_W  = 48;
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Fixed IPv4 header words
  localparam logic [15:0] IP_VER_IHL_TOS = 16'h4500;
  localparam logic [15:0] IP_IDENT       = 16'd54321;
  localparam logic [15:0] IP_FLAGS_FRAG  = 16'h0000;
  localparam logic [15:0] IP_TTL_PROTO   = 16'h4011;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [15:0] UDP_CSUM       = 16'h0000;

  localparam logic [15:0] ETHER_TYPE_RESET = 16'h0800;

  // Configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_DEST_MAC   = 3'd0,
    REG_SRC_MAC    = 3'd1,
    REG_ETHER_TYPE = 3'd2,
    REG_SRC_IP     = 3'd3,
    REG_DEST_IP    = 3'd4,
    REG_SRC_PORT   = 3'd5,
    REG_DEST_PORT  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [47:0] dest_mac_addr;
    logic [47:0] src_mac_addr;
    logic [15:0] ether_type_value;
    logic [31:0] src_ip_addr;
    logic [31:0] dest_ip_addr;
    logic [15:0] src_udp_port;
    logic [15:0] dest_udp_port;
  } cfg_t;

  // Request item
  typedef struct packed {
    logic [15:0] ip_total_length;
    logic [15:0] udp_payload_length;
  } req_t;

  // Result item
  typedef struct packed {
    logic [15:0] header_word;
    logic        last_word;
  } hdr_t;

  // Per-packet fields worked out by the front end
  typedef struct packed {
    logic [15:0] total_len;
    logic [15:0] ip_csum;
    logic [15:0] udp_len;
  } entry_t;

endpackage

// ----- src/udphb_front.sv -----
// Front end of the header builder: takes a request item, works out the
// IPv4 checksum and UDP length, and pushes an entry into the queue.
// Depends on udphb_pkg.
module udphb_front (
  input  logic               req_valid,
  output logic               req_ready,
  input  udphb_pkg::req_t    req,
  input  udphb_pkg::cfg_t    cfg,
  input  logic               queue_full,
  output logic               push,
  output udphb_pkg::entry_t  push_entry
);

  logic [19:0] sum;
  logic [16:0] fold1;
  logic [16:0] fold2;

  assign req_ready = !queue_full;
  assign push      = req_valid && req_ready;

  // Ones' complement sum of the IPv4 header words, checksum taken as zero
  always_comb begin
    sum = 20'(udphb_pkg::IP_VER_IHL_TOS) + 20'(udphb_pkg::IP_IDENT)
        + 20'(udphb_pkg::IP_FLAGS_FRAG) + 20'(udphb_pkg::IP_TTL_PROTO)
        + 20'(req.ip_total_length)
        + 20'(cfg.src_ip_addr[31:16]) + 20'(cfg.src_ip_addr[15:0])
        + 20'(cfg.dest_ip_addr[31:16]) + 20'(cfg.dest_ip_addr[15:0]);
    fold1 = 17'(sum[15:0]) + 17'(sum[19:16]);
    fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
  end

  always_comb begin
    push_entry.total_len = req.ip_total_length;
    push_entry.ip_csum   = ~fold2[15:0];
    push_entry.udp_len   = req.udp_payload_length + udphb_pkg::UDP_HDR_LEN;
  end

endmodule

// ----- src/udphb_queue.sv -----
// Short queue of per-packet entries between the front and back ends.
// Depends on udphb_pkg.
module udphb_queue #(
  parameter int unsigned DEPTH = udphb_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  udphb_pkg::entry_t  push_entry,
  input  logic               pop,
  output logic               full,
  output logic               not_empty,
  output udphb_pkg::entry_t  head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  udphb_pkg::entry_t slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      priority if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_FULL) else $error("queue count above depth");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");

endmodule

// ----- src/udphb_back.sv -----
// Back end of the header builder: walks the 21 header words of the entry
// at the queue head into a registered output. Depends on udphb_pkg.
module udphb_back (
  input  logic               clk,
  input  logic               rst,
  input  udphb_pkg::cfg_t    cfg,
  input  logic               entry_valid,
  input  udphb_pkg::entry_t  entry,
  output logic               pop,
  output logic               hdr_valid,
  input  logic               hdr_ready,
  output udphb_pkg::hdr_t    hdr
);

  localparam logic [udphb_pkg::WORD_IDX_W-1:0] IDX_LAST =
    udphb_pkg::WORD_IDX_W'(udphb_pkg::HDR_WORDS - 1);

  logic [udphb_pkg::WORD_IDX_W-1:0] idx;
  logic        emit;
  logic        at_last;
  logic [15:0] word;

  assign at_last = (idx == IDX_LAST);
  assign emit    = entry_valid && (!hdr_valid || hdr_ready);
  assign pop     = emit && at_last;

  // Word select in transmit order
  always_comb begin
    unique case (idx)
      5'd0:    word = cfg.dest_mac_addr[47:32];
      5'd1:    word = cfg.dest_mac_addr[31:16];
      5'd2:    word = cfg.dest_mac_addr[15:0];
      5'd3:    word = cfg.src_mac_addr[47:32];
      5'd4:    word = cfg.src_mac_addr[31:16];
      5'd5:    word = cfg.src_mac_addr[15:0];
      5'd6:    word = cfg.ether_type_value;
      5'd7:    word = udphb_pkg::IP_VER_IHL_TOS;
      5'd8:    word = entry.total_len;
      5'd9:    word = udphb_pkg::IP_IDENT;
      5'd10:   word = udphb_pkg::IP_FLAGS_FRAG;
      5'd11:   word = udphb_pkg::IP_TTL_PROTO;
      5'd12:   word = entry.ip_csum;
      5'd13:   word = cfg.src_ip_addr[31:16];
      5'd14:   word = cfg.src_ip_addr[15:0];
      5'd15:   word = cfg.dest_ip_addr[31:16];
      5'd16:   word = cfg.dest_ip_addr[15:0];
      5'd17:   word = cfg.src_udp_port;
      5'd18:   word = cfg.dest_udp_port;
      5'd19:   word = entry.udp_len;
      5'd20:   word = udphb_pkg::UDP_CSUM;
      default: word = '0;
    endcase
  end

  // Word counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (emit) begin
      idx <= at_last ? '0 : idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hdr_valid <= 1'b0;
    end else if (emit) begin
      hdr_valid <= 1'b1;
    end else if (hdr_ready) begin
      hdr_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      hdr.header_word <= word;
      hdr.last_word   <= at_last;
    end
  end

  a_idx_bound: assert property (@(posedge clk) disable iff (rst)
    idx <= IDX_LAST) else $error("word index past end of header");

  a_last_flag: assert property (@(posedge clk) disable iff (rst)
    emit |=> (hdr.last_word == (idx == '0))) else $error("last flag out of step");

  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    !entry_valid |=> $stable(idx)) else $error("index moved with no entry");

endmodule

// ----- src/udp_ipv4_ethernet_header_builder.sv -----
// Top level of the Ethernet/IPv4/UDP header builder: configuration
// registers, front end, entry queue and back end.
// Depends on udphb_pkg, udphb_front, udphb_queue and udphb_back.
//
// Usage:
//   req channel (req_valid/req_ready/req): one item per packet, carrying
//   the IPv4 total length and the UDP payload length.
//   hdr channel (hdr_valid/hdr_ready/hdr): 21 items per packet, the
//   42-byte header as big-endian 16-bit words; last_word marks the 21st.
//   Configuration: cfg_we/cfg_index/cfg_data write one register per
//   cycle (0 dest MAC, 1 src MAC, 2 EtherType, 3 src IP, 4 dest IP,
//   5 src port, 6 dest port); index 7 is ignored. Write only while idle.
// Path: a request item is written into the entry queue; its first word then
//   passes through the back end's output register.
// Throughput: one header word per cycle while hdr_ready stays high. The queue
//   (QUEUE_DEPTH entries) takes further requests while a header is still
//   being sent.
// Reset: queue emptied, no word pending, registers back to their reset
//   values (all zero, EtherType 0x0800).
// Stall: a low hdr_ready holds the current word; the back end stops and
//   req_ready drops once the queue is full.
module udp_ipv4_ethernet_header_builder #(
  parameter int unsigned QUEUE_DEPTH = udphb_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             req_valid,
  output logic                             req_ready,
  input  udphb_pkg::req_t                  req,
  output logic                             hdr_valid,
  input  logic                             hdr_ready,
  output udphb_pkg::hdr_t                  hdr,
  input  logic                             cfg_we,
  input  logic [udphb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [udphb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  udphb_pkg::cfg_t   cfg;
  udphb_pkg::entry_t push_entry;
  udphb_pkg::entry_t head;
  logic push;
  logic pop;
  logic queue_full;
  logic queue_not_empty;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dest_mac_addr    <= '0;
      cfg.src_mac_addr     <= '0;
      cfg.ether_type_value <= udphb_pkg::ETHER_TYPE_RESET;
      cfg.src_ip_addr      <= '0;
      cfg.dest_ip_addr     <= '0;
      cfg.src_udp_port     <= '0;
      cfg.dest_udp_port    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        udphb_pkg::REG_DEST_MAC:   cfg.dest_mac_addr    <= cfg_data;
        udphb_pkg::REG_SRC_MAC:    cfg.src_mac_addr     <= cfg_data;
        udphb_pkg::REG_ETHER_TYPE: cfg.ether_type_value <= cfg_data[15:0];
        udphb_pkg::REG_SRC_IP:     cfg.src_ip_addr      <= cfg_data[31:0];
        udphb_pkg::REG_DEST_IP:    cfg.dest_ip_addr     <= cfg_data[31:0];
        udphb_pkg::REG_SRC_PORT:   cfg.src_udp_port     <= cfg_data[15:0];
        udphb_pkg::REG_DEST_PORT:  cfg.dest_udp_port    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  udphb_front u_front (
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  udphb_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (queue_not_empty),
    .head       (head)
  );

  udphb_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .entry_valid (queue_not_empty),
    .entry       (head),
    .pop         (pop),
    .hdr_valid   (hdr_valid),
    .hdr_ready   (hdr_ready),
    .hdr         (hdr)
  );

endmodule

// ----- dv/udp_ipv4_ethernet_header_builder_tb.sv -----
// Testbench for udp_ipv4_ethernet_header_builder: directed and random packet requests,
// each checked word by word against a local header predictor.
// Depends on udphb_pkg and the RTL under src.
module udp_ipv4_ethernet_header_builder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 25;
  localparam logic [udphb_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  udphb_pkg::req_t req = '0;
  logic hdr_valid;
  logic hdr_ready = 1'b0;
  udphb_pkg::hdr_t hdr;
  logic cfg_we = 1'b0;
  logic [udphb_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [udphb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Register copy used for prediction, kept in step with every write
  udphb_pkg::cfg_t shadow_cfg;
  udphb_pkg::hdr_t pending_words[$];
  udphb_pkg::hdr_t want;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit no_gaps = 1'b0;

  udp_ipv4_ethernet_header_builder u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .hdr_valid(hdr_valid),
    .hdr_ready(hdr_ready),
    .hdr(hdr),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Header prediction: 21 words queued per accepted request
  function automatic void predict_header(input udphb_pkg::cfg_t c, input udphb_pkg::req_t r);
    logic [15:0] words[udphb_pkg::HDR_WORDS];
    logic [31:0] sum;
    udphb_pkg::hdr_t item;
    words[0] = c.dest_mac_addr[47:32];
    words[1] = c.dest_mac_addr[31:16];
    words[2] = c.dest_mac_addr[15:0];
    words[3] = c.src_mac_addr[47:32];
    words[4] = c.src_mac_addr[31:16];
    words[5] = c.src_mac_addr[15:0];
    words[6] = c.ether_type_value;
    words[7] = 16'h4500;
    words[8] = r.ip_total_length;
    words[9] = 16'd54321;
    words[10] = 16'h0000;
    words[11] = {8'd64, 8'd17};
    words[12] = 16'h0000;
    words[13] = c.src_ip_addr[31:16];
    words[14] = c.src_ip_addr[15:0];
    words[15] = c.dest_ip_addr[31:16];
    words[16] = c.dest_ip_addr[15:0];
    // ones' complement sum over the IPv4 header, end-around carry folded twice
    sum = 32'd0;
    for (int k = 7; k < 17; k++) sum += {16'd0, words[k]};
    sum = (sum >> 16) + (sum & 32'h0000_FFFF);
    sum = sum + (sum >> 16);
    words[12] = ~sum[15:0];
    words[17] = c.src_udp_port;
    words[18] = c.dest_udp_port;
    words[19] = r.udp_payload_length + 16'd8;
    words[20] = 16'h0000;
    for (int k = 0; k < udphb_pkg::HDR_WORDS; k++) begin
      item.header_word = words[k];
      item.last_word = (k == udphb_pkg::HDR_WORDS - 1);
      pending_words.push_back(item);
    end
  endfunction

  // Requests and header words both observed on the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) predict_header(shadow_cfg, req);
      if (hdr_valid && hdr_ready) begin
        if (pending_words.size() == 0) begin
          $display("%0t: unexpected header word: actual %h last %b", $time,
                   hdr.header_word, hdr.last_word);
          mismatches++;
        end else begin
          want = pending_words.pop_front();
          if (hdr.header_word !== want.header_word) begin
            $display("%0t: header_word mismatch: expected %h actual %h", $time,
                     want.header_word, hdr.header_word);
            mismatches++;
          end
          if (hdr.last_word !== want.last_word) begin
            $display("%0t: last_word mismatch: expected %b actual %b", $time,
                     want.last_word, hdr.last_word);
            mismatches++;
          end
        end
      end
    end
  end

  // Receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      hdr_ready = 1'b0;
      stall_left--;
    end else if (!no_gaps && !rst && $urandom_range(0, 7) == 0) begin
      hdr_ready = 1'b0;
      stall_left = $urandom_range(0, 5);
    end else begin
      hdr_ready = 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Register write while idle; shadow copy masks to the register width
  task automatic write_reg(input logic [udphb_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [47:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    case (idx)
      udphb_pkg::REG_DEST_MAC:   shadow_cfg.dest_mac_addr = data;
      udphb_pkg::REG_SRC_MAC:    shadow_cfg.src_mac_addr = data;
      udphb_pkg::REG_ETHER_TYPE: shadow_cfg.ether_type_value = data[15:0];
      udphb_pkg::REG_SRC_IP:     shadow_cfg.src_ip_addr = data[31:0];
      udphb_pkg::REG_DEST_IP:    shadow_cfg.dest_ip_addr = data[31:0];
      udphb_pkg::REG_SRC_PORT:   shadow_cfg.src_udp_port = data[15:0];
      udphb_pkg::REG_DEST_PORT:  shadow_cfg.dest_udp_port = data[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all_regs(input logic [47:0] dmac, input logic [47:0] smac,
                                input logic [47:0] etype, input logic [47:0] sip,
                                input logic [47:0] dip, input logic [47:0] sport,
                                input logic [47:0] dport);
    write_reg(udphb_pkg::REG_DEST_MAC, dmac);
    write_reg(udphb_pkg::REG_SRC_MAC, smac);
    write_reg(udphb_pkg::REG_ETHER_TYPE, etype);
    write_reg(udphb_pkg::REG_SRC_IP, sip);
    write_reg(udphb_pkg::REG_DEST_IP, dip);
    write_reg(udphb_pkg::REG_SRC_PORT, sport);
    write_reg(udphb_pkg::REG_DEST_PORT, dport);
  endtask

  // One request item; called and returns at a falling edge, valid left high
  task automatic send_request(input logic [15:0] total_len, input logic [15:0] payload);
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_valid = 1'b1;
    req.ip_total_length = total_len;
    req.udp_payload_length = payload;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // Drop valid and wait for every queued word to come out
  task automatic wait_idle();
    req_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  function automatic logic [47:0] rand_value();
    case ($urandom_range(0, 3))
      0: return 48'h0;
      1: return {48{1'b1}};
      default: return 48'({$urandom, $urandom});
    endcase
  endfunction

  task automatic test_reset_defaults();
    send_request(16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF);
    // payload that wraps UDP length to zero
    send_request(16'h8000, 16'hFFF8);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    // all ones, with wide data on narrow registers to check masking
    write_all_regs({48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}}, {48{1'b1}},
                   {48{1'b1}}, {48{1'b1}});
    // out-of-range index must change nothing
    write_reg(REG_UNUSED, 48'h5A5A_A5A5_1234);
    send_request(16'hFFFF, 16'hFFF7);
    send_request(16'h0000, 16'h0000);
    send_request(16'h5555, 16'hAAAA);
    send_request(16'hAAAA, 16'h5555);
    wait_idle();
    write_all_regs(48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0, 48'h0);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h001C, 16'h0000);
    wait_idle();
    // distinct values per register so swapped words show up
    write_all_regs(48'h0102_0304_0506, 48'hA1A2_A3A4_A5A6, 48'hFFFF_FFFF_86DD,
                   48'hFFFF_C0A8_0001, 48'h0000_0A00_00FE, 48'h1234_0400, 48'h0000_FFFF);
    send_request(16'h0024, 16'h0008);
    wait_idle();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    for (int n = 0; n < 8; n++) begin
      send_request(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
    end
    wait_idle();
    no_gaps = 1'b0;
  endtask

  task automatic test_random_traffic();
    int unsigned count;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase == 7) no_gaps = 1'b1;
      write_all_regs(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                     rand_value(), rand_value());
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, rand_value());
      count = $urandom_range(20, 28);
      for (int n = 0; n < count; n++) begin
        case ($urandom_range(0, 5))
          0: send_request(16'($urandom_range(0, 65535)),
                          16'($urandom_range(65528, 65535)));
          1: send_request(16'($urandom_range(20, 1500)), 16'($urandom_range(0, 1472)));
          default: send_request(16'($urandom_range(0, 65535)),
                                16'($urandom_range(0, 65535)));
        endcase
      end
      wait_idle();
    end
  endtask

  initial begin
    shadow_cfg = '0;
    shadow_cfg.ether_type_value = 16'h0800;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_register_extremes();
    test_back_to_back();
    test_random_traffic();
    req_valid = 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- udp_ipv4_ethernet_header_builder.f -----
src/udphb_pkg.sv
src/udphb_front.sv
src/udphb_queue.sv
src/udphb_back.sv
src/udp_ipv4_ethernet_header_builder.sv
dv/udp_ipv4_ethernet_header_builder_tb.sv
